@@ sv/ssff_pkg.sv @@
// Shared types and constants for the simplex shared face finder.
package ssff_pkg;

    localparam int FIELD_BITS        = 31;
    localparam int VERTEX_BITS_DEF   = 31;
    localparam int NUM_VERTS         = 4;
    localparam int FACE_SLOTS        = 3;
    localparam logic [1:0] DIM_RESET = 2'd3;

    typedef logic [FIELD_BITS-1:0] field_t;
    typedef logic [1:0]            pos_t;

    typedef struct packed {
        field_t a_vert0;
        field_t a_vert1;
        field_t a_vert2;
        field_t a_vert3;
        field_t b_vert0;
        field_t b_vert1;
        field_t b_vert2;
        field_t b_vert3;
    } item_word_t;

    typedef struct packed {
        field_t face_vert0;
        field_t face_vert1;
        field_t face_vert2;
        pos_t   a_pos0;
        pos_t   a_pos1;
        pos_t   a_pos2;
        pos_t   b_pos0;
        pos_t   b_pos1;
        pos_t   b_pos2;
        pos_t   shared_count;
    } result_word_t;

endpackage

@@ sv/ssff_core.sv @@
// Combinational match, compaction and sort of two simplices' vertex lists.
module ssff_core #(
    parameter int VW = ssff_pkg::VERTEX_BITS_DEF
) (
    input  logic [ssff_pkg::NUM_VERTS-1:0][VW-1:0]  a,
    input  logic [ssff_pkg::NUM_VERTS-1:0][VW-1:0]  b,
    input  logic [1:0]                              dim,
    output logic [ssff_pkg::FACE_SLOTS-1:0][VW-1:0] face,
    output logic [ssff_pkg::FACE_SLOTS-1:0][1:0]    apos,
    output logic [ssff_pkg::FACE_SLOTS-1:0][1:0]    bpos,
    output logic [1:0]                              count
);
    import ssff_pkg::*;

    logic [NUM_VERTS-1:0]             hit;
    logic [NUM_VERTS-1:0][1:0]        first;
    logic [FACE_SLOTS-1:0][VW-1:0]    fv;
    logic [FACE_SLOTS-1:0][1:0]       pa;
    logic [FACE_SLOTS-1:0][1:0]       pb;
    logic [1:0]                       cnt;
    logic [VW-1:0]                    tv;
    logic [1:0]                       tp;

    // lowest matching position of b for each vertex of a
    always_comb
    begin
        for (int k = 0; k < NUM_VERTS; k++)
        begin
            hit[k]   = 1'b0;
            first[k] = 2'd0;
            for (int l = NUM_VERTS - 1; l >= 0; l--)
            begin
                if ((2'(k) <= dim) && (2'(l) <= dim) && (a[k] == b[l]))
                begin
                    hit[k]   = 1'b1;
                    first[k] = 2'(l);
                end
            end
        end
    end

    // pack matches in scan order, stop once dim are found
    always_comb
    begin
        fv  = '0;
        pa  = '0;
        pb  = '0;
        cnt = 2'd0;
        for (int k = 0; k < NUM_VERTS; k++)
        begin
            if (hit[k] && (cnt < dim))
            begin
                fv[cnt] = a[k];
                pa[cnt] = 2'(k);
                pb[cnt] = first[k];
                cnt     = cnt + 2'd1;
            end
        end
    end

    // three-slot sort over the filled prefix only; a positions already ascend
    always_comb
    begin
        face = fv;
        bpos = pb;
        tv   = '0;
        tp   = '0;
        if (cnt >= 2'd2 && face[0] > face[1])
        begin
            tv = face[0]; face[0] = face[1]; face[1] = tv;
        end
        if (cnt == 2'd3 && face[1] > face[2])
        begin
            tv = face[1]; face[1] = face[2]; face[2] = tv;
        end
        if (cnt >= 2'd2 && face[0] > face[1])
        begin
            tv = face[0]; face[0] = face[1]; face[1] = tv;
        end
        if (cnt >= 2'd2 && bpos[0] > bpos[1])
        begin
            tp = bpos[0]; bpos[0] = bpos[1]; bpos[1] = tp;
        end
        if (cnt == 2'd3 && bpos[1] > bpos[2])
        begin
            tp = bpos[1]; bpos[1] = bpos[2]; bpos[2] = tp;
        end
        if (cnt >= 2'd2 && bpos[0] > bpos[1])
        begin
            tp = bpos[0]; bpos[0] = bpos[1]; bpos[1] = tp;
        end
    end

    assign apos  = pa;
    assign count = cnt;

endmodule

@@ sv/simplex_shared_face_finder.sv @@
// Top level: shared face of two simplices, input and result registers around the core.
//
// Takes one pair of simplices per word and returns one result word per input word:
// shared vertices ascending, matched local positions in each element ascending,
// and the match count (equal to dim for a full face; unused slots read zero).
// Sustains one word per clock while result_stall is low; an input register then a
// result register hold each word, with all matching and sorting in the logic between them.
// The user must write dim_data only while no word is in flight (the block does not enforce this); reset value is 3.
module simplex_shared_face_finder #(
    parameter int VERTEX_BITS = ssff_pkg::VERTEX_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  ssff_pkg::item_word_t   item_word,
    output logic                   result_valid,
    input  logic                   result_stall,
    output ssff_pkg::result_word_t result_word,
    input  logic                   dim_we,
    input  logic [1:0]             dim_data
);
    import ssff_pkg::*;

    logic [1:0]                             dim_reg;
    logic                                   stage_vld_reg;
    logic [NUM_VERTS-1:0][VERTEX_BITS-1:0]  a_reg;
    logic [NUM_VERTS-1:0][VERTEX_BITS-1:0]  b_reg;
    logic                                   out_vld_reg;
    result_word_t                           out_reg;
    result_word_t                           out_next;

    logic [FACE_SLOTS-1:0][VERTEX_BITS-1:0] face;
    logic [FACE_SLOTS-1:0][1:0]             apos;
    logic [FACE_SLOTS-1:0][1:0]             bpos;
    logic [1:0]                             count;
    logic                                   out_adv;
    logic                                   in_take;

    assign out_adv    = !out_vld_reg || !result_stall;
    assign item_stall = stage_vld_reg && !out_adv;
    assign in_take    = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DIM_RESET;
        end
        else if (dim_we)
        begin
            dim_reg <= dim_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (in_take)
                stage_vld_reg <= 1'b1;
            else if (out_adv)
                stage_vld_reg <= 1'b0;
            if (out_adv)
                out_vld_reg <= stage_vld_reg;
        end
    end

    // bits above VERTEX_BITS are dropped on entry
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_reg[0] <= item_word.a_vert0[VERTEX_BITS-1:0];
            a_reg[1] <= item_word.a_vert1[VERTEX_BITS-1:0];
            a_reg[2] <= item_word.a_vert2[VERTEX_BITS-1:0];
            a_reg[3] <= item_word.a_vert3[VERTEX_BITS-1:0];
            b_reg[0] <= item_word.b_vert0[VERTEX_BITS-1:0];
            b_reg[1] <= item_word.b_vert1[VERTEX_BITS-1:0];
            b_reg[2] <= item_word.b_vert2[VERTEX_BITS-1:0];
            b_reg[3] <= item_word.b_vert3[VERTEX_BITS-1:0];
        end
        if (out_adv && stage_vld_reg)
        begin
            out_reg <= out_next;
        end
    end

    ssff_core #(
        .VW (VERTEX_BITS)
    ) u_core (
        .a     (a_reg),
        .b     (b_reg),
        .dim   (dim_reg),
        .face  (face),
        .apos  (apos),
        .bpos  (bpos),
        .count (count)
    );

    always_comb
    begin
        out_next              = '0;
        out_next.face_vert0   = field_t'(face[0]);
        out_next.face_vert1   = field_t'(face[1]);
        out_next.face_vert2   = field_t'(face[2]);
        out_next.a_pos0       = apos[0];
        out_next.a_pos1       = apos[1];
        out_next.a_pos2       = apos[2];
        out_next.b_pos0       = bpos[0];
        out_next.b_pos1       = bpos[1];
        out_next.b_pos2       = bpos[2];
        out_next.shared_count = count;
    end

    assign result_valid = out_vld_reg;
    assign result_word  = out_reg;

    a_count_le_dim: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_word.shared_count <= dim_reg))
        else $error("shared count exceeds simplex dimension");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_word.shared_count != 2'd3) |->
            (result_word.face_vert2 == '0 && result_word.a_pos2 == '0
             && result_word.b_pos2 == '0))
        else $error("unused face slot not zero");

    a_pos_ascend: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_word.shared_count >= 2'd2) |->
            (result_word.a_pos0 < result_word.a_pos1
             && result_word.face_vert0 <= result_word.face_vert1))
        else $error("result slots not ascending");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_vld_reg && item_stall) |=> stage_vld_reg)
        else $error("held input word lost while stalled");

endmodule
